// File: design/csp_pkg.sv
// Shared types, sizes and codes for the call-stack time profiler.
// No dependencies; every design file imports this package.
package csp_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FUNC_SLOTS  = 256;
    localparam int PAIR_SLOTS  = 512;

    localparam int SW      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int FW      = $clog2(FUNC_SLOTS);
    localparam int FCNT_W  = $clog2(FUNC_SLOTS + 1);
    localparam int PW      = $clog2(PAIR_SLOTS);
    localparam int PCNT_W  = $clog2(PAIR_SLOTS + 1);
    localparam int SCAN_W  = (FW > PW) ? FW : PW;
    localparam int CMP_W   = 16;

    localparam logic [2:0] ACT_ENTER     = 3'd0;
    localparam logic [2:0] ACT_LEAVE     = 3'd1;
    localparam logic [2:0] ACT_SUSPEND   = 3'd2;
    localparam logic [2:0] ACT_RESUME    = 3'd3;
    localparam logic [2:0] ACT_READ_FUNC = 3'd4;
    localparam logic [2:0] ACT_READ_PAIR = 3'd5;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_TABLE = 3'd3;
    localparam logic [2:0] ST_SLOT  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FSCAN,
        S_E_FCHK,
        S_PSCAN,
        S_E_PCHK,
        S_E_COMMIT,
        S_L_TOP,
        S_L_FUNC,
        S_L_PAIR,
        S_R_TOP,
        S_R_FUNC,
        S_RF,
        S_RP1,
        S_RP2,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        FSEL_SCAN,
        FSEL_STACK,
        FSEL_SLOT,
        FSEL_CALLEE
    } fsel_t;

    typedef enum logic {
        PSEL_SCAN,
        PSEL_SLOT
    } psel_t;

    typedef struct packed {
        logic [FW-1:0] slot;
        logic [63:0]   start;
    } frame_t;

    typedef struct packed {
        logic [31:0]        ident;
        logic [31:0]        calls;
        logic [DEPTH_W-1:0] nesting;
        logic [63:0]        cycles;
        logic [63:0]        rec_cycles;
        logic [63:0]        susp_cycles;
    } func_entry_t;

    typedef struct packed {
        logic [FW-1:0]      caller;
        logic [FW-1:0]      callee;
        logic [31:0]        calls;
        logic [DEPTH_W-1:0] nesting;
        logic [63:0]        cycles;
        logic [63:0]        rec_cycles;
    } pair_entry_t;

    typedef struct packed {
        logic       cap;
        logic       stk_rd;
        logic       push;
        logic       pop;
        logic       scan_clr;
        logic       scan_inc;
        logic       f_rd;
        fsel_t      f_sel;
        logic       f_wr_enter;
        logic       f_wr_leave;
        logic       f_wr_resume;
        logic       p_rd;
        psel_t      p_sel;
        logic       p_wr_enter;
        logic       p_wr_leave;
        logic       f_match_set;
        logic       f_new_set;
        logic       f_from_stack;
        logic       p_match_set;
        logic       p_new_set;
        logic       el_leave;
        logic       el_resume;
        logic       susp_latch;
        logic       st_we;
        logic [2:0] st_code;
        logic       res_func_load;
        logic       res_pair_load;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic       depth_zero;
        logic       depth_full;
        logic       fcnt_zero;
        logic       pcnt_zero;
        logic       f_full;
        logic       p_full;
        logic       f_match;
        logic       f_last;
        logic       p_match;
        logic       p_last;
        logic       f_found;
        logic       p_found;
        logic       slot_bad_f;
        logic       slot_bad_p;
    } stat_t;

endpackage

// File: design/call_stack_time_profiler.sv
// Call-stack time profiler top level: csp_ctrl sequences csp_dpath. Uses csp_pkg.
// One item at a time. Enter walks the filled function slots and then the filled
// pair slots with the one-entry-a-cycle scan; leave walks the filled pair slots.
// Reset (rst_n low, async) empties the stack and zeroes fill counts and totals;
// table entries are initialized when allocated, so no clearing pass is needed.
module call_stack_time_profiler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [31:0] function_id,
    input  logic [63:0] timestamp,
    input  logic [8:0]  slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [63:0] elapsed,
    output logic [31:0] entry_function_id,
    output logic [7:0]  entry_caller_slot,
    output logic [31:0] entry_calls,
    output logic [63:0] entry_cycles,
    output logic [63:0] entry_recursive_cycles,
    output logic [63:0] entry_suspend_cycles,
    output logic [63:0] thread_suspend_total
);
    import csp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: takes a beat only while idle, parks the result in the
    // output register, and accepts the next beat while that result waits
    csp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // stack, function and pair tables, scan counter and output register
    csp_dpath u_dpath (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .stat                   (stat),
        .action                 (action),
        .function_id            (function_id),
        .timestamp              (timestamp),
        .slot                   (slot),
        .status                 (status),
        .elapsed                (elapsed),
        .entry_function_id      (entry_function_id),
        .entry_caller_slot      (entry_caller_slot),
        .entry_calls            (entry_calls),
        .entry_cycles           (entry_cycles),
        .entry_recursive_cycles (entry_recursive_cycles),
        .entry_suspend_cycles   (entry_suspend_cycles),
        .thread_suspend_total   (thread_suspend_total)
    );

endmodule

// File: design/csp_ctrl.sv
// Sequencer of the call-stack time profiler: handshakes and per-action steps.
// Depends on csp_pkg; drives csp_dpath through cmd_t and reads stat_t.
module csp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  csp_pkg::stat_t stat,
    output csp_pkg::cmd_t  cmd
);
    import csp_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (state_reg == S_DONE && out_free)
            out_valid_next = 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
                unique case (stat.act)
                    ACT_ENTER:
                        if (stat.depth_full)
                            state_next = S_DONE;
                        else if (stat.fcnt_zero)
                            state_next = S_E_FCHK;
                        else
                            state_next = S_FSCAN;
                    ACT_LEAVE:
                        state_next = stat.depth_zero ? S_DONE : S_L_TOP;
                    ACT_RESUME:
                        state_next = stat.depth_zero ? S_DONE : S_R_TOP;
                    ACT_READ_FUNC:
                        state_next = stat.slot_bad_f ? S_DONE : S_RF;
                    ACT_READ_PAIR:
                        state_next = stat.slot_bad_p ? S_DONE : S_RP1;
                    default:
                        state_next = S_DONE;
                endcase
            S_FSCAN:
                if (stat.f_match || stat.f_last)
                    state_next = S_E_FCHK;
            S_E_FCHK:
                if (!stat.f_found && stat.f_full)
                    state_next = S_DONE;
                else if (stat.depth_zero)
                    state_next = S_E_COMMIT;
                else if (!stat.f_found || stat.pcnt_zero)
                    state_next = S_E_PCHK;
                else
                    state_next = S_PSCAN;
            S_PSCAN:
                if (stat.p_match)
                    state_next = (stat.act == ACT_ENTER) ? S_E_PCHK : S_L_PAIR;
                else if (stat.p_last)
                    state_next = (stat.act == ACT_ENTER) ? S_E_PCHK : S_DONE;
            S_E_PCHK:
                state_next = (!stat.p_found && stat.p_full) ? S_DONE : S_E_COMMIT;
            S_E_COMMIT:
                state_next = S_DONE;
            S_L_TOP:
                state_next = S_L_FUNC;
            S_L_FUNC:
                if (stat.depth_zero || stat.pcnt_zero)
                    state_next = S_DONE;
                else
                    state_next = S_PSCAN;
            S_L_PAIR:
                state_next = S_DONE;
            S_R_TOP:
                state_next = S_R_FUNC;
            S_R_FUNC:
                state_next = S_DONE;
            S_RF:
                state_next = S_DONE;
            S_RP1:
                state_next = S_RP2;
            S_RP2:
                state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
                cmd.cap = in_valid;
            S_DECODE:
                unique case (stat.act)
                    ACT_ENTER:
                        if (stat.depth_full)
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.stk_rd   = 1'b1;
                            cmd.scan_clr = 1'b1;
                            cmd.f_rd     = 1'b1;
                            cmd.f_sel    = FSEL_SCAN;
                            if (stat.fcnt_zero)
                                cmd.f_new_set = 1'b1;
                        end
                    ACT_LEAVE:
                        if (stat.depth_zero)
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ST_EMPTY;
                        end
                        else
                            cmd.stk_rd = 1'b1;
                    ACT_SUSPEND:
                    begin
                        cmd.susp_latch = 1'b1;
                        if (stat.depth_zero)
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ST_EMPTY;
                        end
                    end
                    ACT_RESUME:
                    begin
                        cmd.el_resume = 1'b1;
                        if (stat.depth_zero)
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ST_EMPTY;
                        end
                        else
                            cmd.stk_rd = 1'b1;
                    end
                    ACT_READ_FUNC:
                        if (stat.slot_bad_f)
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ST_SLOT;
                        end
                        else
                        begin
                            cmd.f_rd  = 1'b1;
                            cmd.f_sel = FSEL_SLOT;
                        end
                    ACT_READ_PAIR:
                        if (stat.slot_bad_p)
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ST_SLOT;
                        end
                        else
                        begin
                            cmd.p_rd  = 1'b1;
                            cmd.p_sel = PSEL_SLOT;
                        end
                    default:
                        cmd.st_we = 1'b0;
                endcase
            S_FSCAN:
                if (stat.f_match)
                    cmd.f_match_set = 1'b1;
                else if (stat.f_last)
                    cmd.f_new_set = 1'b1;
                else
                begin
                    cmd.scan_inc = 1'b1;
                    cmd.f_rd     = 1'b1;
                    cmd.f_sel    = FSEL_SCAN;
                end
            S_E_FCHK:
                if (!stat.f_found && stat.f_full)
                begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = ST_TABLE;
                end
                else if (!stat.depth_zero)
                begin
                    if (!stat.f_found || stat.pcnt_zero)
                        cmd.p_new_set = 1'b1;
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        cmd.p_rd     = 1'b1;
                        cmd.p_sel    = PSEL_SCAN;
                    end
                end
            S_PSCAN:
                if (stat.p_match)
                    cmd.p_match_set = 1'b1;
                else if (stat.p_last)
                    cmd.p_new_set = 1'b1;
                else
                begin
                    cmd.scan_inc = 1'b1;
                    cmd.p_rd     = 1'b1;
                    cmd.p_sel    = PSEL_SCAN;
                end
            S_E_PCHK:
                if (!stat.p_found && stat.p_full)
                begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = ST_TABLE;
                end
            S_E_COMMIT:
            begin
                cmd.f_wr_enter = 1'b1;
                cmd.p_wr_enter = !stat.depth_zero;
                cmd.push       = 1'b1;
            end
            S_L_TOP:
            begin
                cmd.f_from_stack = 1'b1;
                cmd.el_leave     = 1'b1;
                cmd.f_rd         = 1'b1;
                cmd.f_sel        = FSEL_STACK;
                cmd.pop          = 1'b1;
            end
            S_L_FUNC:
            begin
                cmd.f_wr_leave = 1'b1;
                if (!stat.depth_zero && !stat.pcnt_zero)
                begin
                    cmd.stk_rd   = 1'b1;
                    cmd.scan_clr = 1'b1;
                    cmd.p_rd     = 1'b1;
                    cmd.p_sel    = PSEL_SCAN;
                end
            end
            S_L_PAIR:
                cmd.p_wr_leave = 1'b1;
            S_R_TOP:
            begin
                cmd.f_from_stack = 1'b1;
                cmd.f_rd         = 1'b1;
                cmd.f_sel        = FSEL_STACK;
            end
            S_R_FUNC:
                cmd.f_wr_resume = 1'b1;
            S_RF:
                cmd.res_func_load = 1'b1;
            S_RP1:
            begin
                cmd.f_rd  = 1'b1;
                cmd.f_sel = FSEL_CALLEE;
            end
            S_RP2:
                cmd.res_pair_load = 1'b1;
            S_DONE:
                cmd.out_load = out_free;
            default:
                cmd.cap = 1'b0;
        endcase
    end

endmodule

// File: design/csp_dpath.sv
// Datapath of the call-stack time profiler: stack, function and pair tables,
// scan counter, totals and output register. Depends on csp_pkg.
module csp_dpath (
    input  logic           clk,
    input  logic           rst_n,
    input  csp_pkg::cmd_t  cmd,
    output csp_pkg::stat_t stat,
    input  logic [2:0]     action,
    input  logic [31:0]    function_id,
    input  logic [63:0]    timestamp,
    input  logic [8:0]     slot,
    output logic [2:0]     status,
    output logic [63:0]    elapsed,
    output logic [31:0]    entry_function_id,
    output logic [7:0]     entry_caller_slot,
    output logic [31:0]    entry_calls,
    output logic [63:0]    entry_cycles,
    output logic [63:0]    entry_recursive_cycles,
    output logic [63:0]    entry_suspend_cycles,
    output logic [63:0]    thread_suspend_total
);
    import csp_pkg::*;

    frame_t      stack_mem [STACK_DEPTH];
    func_entry_t func_mem  [FUNC_SLOTS];
    pair_entry_t pair_mem  [PAIR_SLOTS];

    frame_t      stack_q_reg;
    func_entry_t func_q_reg;
    pair_entry_t pair_q_reg;

    logic [2:0]         act_reg;
    logic [31:0]        id_reg;
    logic [63:0]        ts_reg;
    logic [8:0]         slot_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [FCNT_W-1:0]  fcnt_reg;
    logic [PCNT_W-1:0]  pcnt_reg;
    logic [SCAN_W-1:0]  scan_reg, scan_next;
    logic [FW-1:0]      f_reg;
    logic               f_found_reg;
    logic [PW-1:0]      p_reg;
    logic               p_found_reg;
    logic [63:0]        susp_start_reg;
    logic [63:0]        susp_total_reg;
    logic [63:0]        elapsed_reg;
    logic [2:0]         status_reg;

    logic [31:0] res_ident_reg;
    logic [7:0]  res_caller_reg;
    logic [31:0] res_calls_reg;
    logic [63:0] res_cycles_reg;
    logic [63:0] res_rec_reg;
    logic [63:0] res_susp_reg;

    logic [2:0]  out_status_reg;
    logic [63:0] out_elapsed_reg;
    logic [31:0] out_ident_reg;
    logic [7:0]  out_caller_reg;
    logic [31:0] out_calls_reg;
    logic [63:0] out_cycles_reg;
    logic [63:0] out_rec_reg;
    logic [63:0] out_susp_reg;
    logic [63:0] out_total_reg;

    logic [SW-1:0]      stk_top;
    logic [FW-1:0]      f_rd_addr;
    logic [PW-1:0]      p_rd_addr;
    logic               f_we, p_we;
    func_entry_t        f_wdata;
    pair_entry_t        p_wdata;
    logic [DEPTH_W-1:0] f_nest_dec, p_nest_dec;

    assign stk_top = SW'(depth_reg - DEPTH_W'(1));

    always_comb
    begin
        scan_next = scan_reg;
        if (cmd.scan_clr)
            scan_next = '0;
        else if (cmd.scan_inc)
            scan_next = scan_reg + SCAN_W'(1);
    end

    always_comb
    begin
        case (cmd.f_sel)
            FSEL_SCAN:   f_rd_addr = FW'(scan_next);
            FSEL_STACK:  f_rd_addr = stack_q_reg.slot;
            FSEL_SLOT:   f_rd_addr = FW'(slot_reg);
            FSEL_CALLEE: f_rd_addr = pair_q_reg.callee;
            default:     f_rd_addr = FW'(scan_next);
        endcase
        p_rd_addr = (cmd.p_sel == PSEL_SLOT) ? PW'(slot_reg) : PW'(scan_next);
    end

    // read-modify-write data for the two tables
    always_comb
    begin
        f_wdata    = func_q_reg;
        f_nest_dec = (func_q_reg.nesting != '0) ? func_q_reg.nesting - DEPTH_W'(1) : '0;
        if (cmd.f_wr_enter)
        begin
            if (!f_found_reg)
            begin
                f_wdata       = '0;
                f_wdata.ident = id_reg;
            end
            f_wdata.calls   = f_wdata.calls + 32'd1;
            f_wdata.nesting = f_wdata.nesting + DEPTH_W'(1);
        end
        else if (cmd.f_wr_leave)
        begin
            f_wdata.nesting = f_nest_dec;
            if (f_nest_dec == '0)
                f_wdata.cycles = func_q_reg.cycles + elapsed_reg;
            else
                f_wdata.rec_cycles = func_q_reg.rec_cycles + elapsed_reg;
        end
        else if (cmd.f_wr_resume)
            f_wdata.susp_cycles = func_q_reg.susp_cycles + elapsed_reg;
    end

    always_comb
    begin
        p_wdata    = pair_q_reg;
        p_nest_dec = (pair_q_reg.nesting != '0) ? pair_q_reg.nesting - DEPTH_W'(1) : '0;
        if (cmd.p_wr_enter)
        begin
            if (!p_found_reg)
            begin
                p_wdata        = '0;
                p_wdata.caller = stack_q_reg.slot;
                p_wdata.callee = f_reg;
            end
            p_wdata.calls   = p_wdata.calls + 32'd1;
            p_wdata.nesting = p_wdata.nesting + DEPTH_W'(1);
        end
        else if (cmd.p_wr_leave)
        begin
            p_wdata.nesting = p_nest_dec;
            if (p_nest_dec == '0)
                p_wdata.cycles = pair_q_reg.cycles + elapsed_reg;
            else
                p_wdata.rec_cycles = pair_q_reg.rec_cycles + elapsed_reg;
        end
    end

    assign f_we = cmd.f_wr_enter || cmd.f_wr_leave || cmd.f_wr_resume;
    assign p_we = cmd.p_wr_enter || cmd.p_wr_leave;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.stk_rd)
            stack_q_reg <= stack_mem[stk_top];
        if (cmd.push)
            stack_mem[SW'(depth_reg)] <= '{slot: f_reg, start: ts_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.f_rd)
            func_q_reg <= func_mem[f_rd_addr];
        if (f_we)
            func_mem[f_reg] <= f_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p_rd)
            pair_q_reg <= pair_mem[p_rd_addr];
        if (p_we)
            pair_mem[p_reg] <= p_wdata;
    end

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.push)
            depth_next = depth_reg + DEPTH_W'(1);
        else if (cmd.pop)
            depth_next = depth_reg - DEPTH_W'(1);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= '0;
            fcnt_reg       <= '0;
            pcnt_reg       <= '0;
            susp_start_reg <= '0;
            susp_total_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
            if (cmd.f_wr_enter && !f_found_reg)
                fcnt_reg <= fcnt_reg + FCNT_W'(1);
            if (cmd.p_wr_enter && !p_found_reg)
                pcnt_reg <= pcnt_reg + PCNT_W'(1);
            if (cmd.susp_latch)
                susp_start_reg <= ts_reg;
            if (cmd.f_wr_resume)
                susp_total_reg <= susp_total_reg + elapsed_reg;
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (cmd.cap)
        begin
            act_reg        <= action;
            id_reg         <= function_id;
            ts_reg         <= timestamp;
            slot_reg       <= slot;
            status_reg     <= ST_OK;
            elapsed_reg    <= '0;
            res_ident_reg  <= '0;
            res_caller_reg <= '0;
            res_calls_reg  <= '0;
            res_cycles_reg <= '0;
            res_rec_reg    <= '0;
            res_susp_reg   <= '0;
        end
        if (cmd.st_we)
            status_reg <= cmd.st_code;
        if (cmd.f_match_set)
        begin
            f_reg       <= FW'(scan_reg);
            f_found_reg <= 1'b1;
        end
        else if (cmd.f_new_set)
        begin
            f_reg       <= FW'(fcnt_reg);
            f_found_reg <= 1'b0;
        end
        else if (cmd.f_from_stack)
            f_reg <= stack_q_reg.slot;
        if (cmd.p_match_set)
        begin
            p_reg       <= PW'(scan_reg);
            p_found_reg <= 1'b1;
        end
        else if (cmd.p_new_set)
        begin
            p_reg       <= PW'(pcnt_reg);
            p_found_reg <= 1'b0;
        end
        if (cmd.el_leave)
            elapsed_reg <= ts_reg - stack_q_reg.start;
        else if (cmd.el_resume)
            elapsed_reg <= ts_reg - susp_start_reg;
        if (cmd.res_func_load)
        begin
            res_ident_reg  <= func_q_reg.ident;
            res_calls_reg  <= func_q_reg.calls;
            res_cycles_reg <= func_q_reg.cycles;
            res_rec_reg    <= func_q_reg.rec_cycles;
            res_susp_reg   <= func_q_reg.susp_cycles;
        end
        else if (cmd.res_pair_load)
        begin
            res_ident_reg  <= func_q_reg.ident;
            res_caller_reg <= 8'(pair_q_reg.caller);
            res_calls_reg  <= pair_q_reg.calls;
            res_cycles_reg <= pair_q_reg.cycles;
            res_rec_reg    <= pair_q_reg.rec_cycles;
        end
    end

    // output register, held until the beat is taken
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg  <= status_reg;
            out_elapsed_reg <= elapsed_reg;
            out_ident_reg   <= res_ident_reg;
            out_caller_reg  <= res_caller_reg;
            out_calls_reg   <= res_calls_reg;
            out_cycles_reg  <= res_cycles_reg;
            out_rec_reg     <= res_rec_reg;
            out_susp_reg    <= res_susp_reg;
            out_total_reg   <= susp_total_reg;
        end
    end

    assign status                 = out_status_reg;
    assign elapsed                = out_elapsed_reg;
    assign entry_function_id      = out_ident_reg;
    assign entry_caller_slot      = out_caller_reg;
    assign entry_calls            = out_calls_reg;
    assign entry_cycles           = out_cycles_reg;
    assign entry_recursive_cycles = out_rec_reg;
    assign entry_suspend_cycles   = out_susp_reg;
    assign thread_suspend_total   = out_total_reg;

    assign stat.act        = act_reg;
    assign stat.depth_zero = (depth_reg == '0);
    assign stat.depth_full = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign stat.fcnt_zero  = (fcnt_reg == '0);
    assign stat.pcnt_zero  = (pcnt_reg == '0);
    assign stat.f_full     = (fcnt_reg == FCNT_W'(FUNC_SLOTS));
    assign stat.p_full     = (pcnt_reg == PCNT_W'(PAIR_SLOTS));
    assign stat.f_match    = (func_q_reg.ident == id_reg);
    assign stat.f_last     = (CMP_W'(scan_reg) + CMP_W'(1)) == CMP_W'(fcnt_reg);
    assign stat.p_match    = (pair_q_reg.caller == stack_q_reg.slot)
                          && (pair_q_reg.callee == f_reg);
    assign stat.p_last     = (CMP_W'(scan_reg) + CMP_W'(1)) == CMP_W'(pcnt_reg);
    assign stat.f_found    = f_found_reg;
    assign stat.p_found    = p_found_reg;
    assign stat.slot_bad_f = CMP_W'(slot_reg) >= CMP_W'(fcnt_reg);
    assign stat.slot_bad_p = CMP_W'(slot_reg) >= CMP_W'(pcnt_reg);

endmodule
